@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the self-test sequencer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sst_seq: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sst_seq: assertion failed");

// In the cycle after the antecedent, checked also while reset is high.
`define SST_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sst_seq: assertion failed");

`endif

@@ rtl/sst_seq_pkg.sv @@
// ---------------------------------------------------------------------------
// sst_seq_pkg
// Types, codes and constants of the memory self-test sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package sst_seq_pkg;

  localparam int SIZE_BITS = 24;
  localparam int SIZE_W    = SIZE_BITS + 1;
  localparam int ADDR_W    = 32;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1) << SIZE_BITS;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32768);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;

  // Configuration register indexes.
  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_REGION_SIZE  = 1'b1;

  // Input beat kinds.
  localparam logic MODE_START    = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  // Test selections.
  localparam logic [1:0] TEST_WALK_ONES  = 2'd0;
  localparam logic [1:0] TEST_WALK_ZEROS = 2'd1;
  localparam logic [1:0] TEST_ADDR_BUS   = 2'd2;
  localparam logic [1:0] TEST_FILL       = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Address-bus test phases.
  localparam logic [2:0] ADDR_LOW_FILL   = 3'd0;
  localparam logic [2:0] ADDR_BASE_AA    = 3'd1;
  localparam logic [2:0] ADDR_LOW_CHECK  = 3'd2;
  localparam logic [2:0] ADDR_HIGH_FILL  = 3'd3;
  localparam logic [2:0] ADDR_BASE_55    = 3'd4;
  localparam logic [2:0] ADDR_HIGH_CHECK = 3'd5;
  localparam logic [2:0] ADDR_END        = 3'd6;

  // Device fill phases.
  localparam logic [2:0] FILL_WRITE = 3'd0;

  localparam logic [7:0] PATTERN_AA = 8'hAA;
  localparam logic [7:0] PATTERN_55 = 8'h55;
  localparam logic [7:0] FILL_SEED  = 8'd5;

  typedef struct packed {
    logic [ADDR_W-1:0] fail_address;
    logic              test_passed;
    logic [7:0]        write_data;
    logic [ADDR_W-1:0] access_address;
    logic [1:0]        access_kind;
  } result_t;

  function automatic logic [7:0] walk_pattern(input logic [1:0] test, input logic [2:0] idx);
    logic [7:0] one_hot;
    one_hot = 8'h01 << idx;
    return (test == TEST_WALK_ONES) ? one_hot : ~one_hot;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sram_self_test_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// sram_self_test_sequencer_top
// Byte-wide memory self-test sequencer: walking ones, walking zeros,
// address bus and device fill tests over a configurable region.
// ---------------------------------------------------------------------------
// Channel   Direction  Carries
// s_*       in         start beats and access completions
// m_*       out        write and read requests, done reports
// cfg_*     in         register writes (0 base address, 1 region size)
//
// One beat is taken per cycle while no result waits in the skid stage. A
// beat goes through the input register, the decision logic and the result
// register. One result can wait in a skid stage, so a stalled output still
// lets the next beat in. Reset is synchronous and returns the block
// to idle with base address 0 and region size 32768.
// ---------------------------------------------------------------------------
`default_nettype none

module sram_self_test_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // test_select[1:0], read_data[9:2], zeros
  input  wire logic [0:0]  s_tuser,   // mode[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // access_address[31:0], write_data[39:32],
                                      // test_passed[40], fail_address[72:41], zeros
  output logic [1:0]       m_tuser,   // access_kind[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [sst_seq_pkg::ADDR_W-1:0] base_address;
  logic [sst_seq_pkg::SIZE_W-1:0] region_size;
  logic [sst_seq_pkg::SIZE_W-1:0] eff_size;

  logic       in_valid;
  logic       in_mode;
  logic [1:0] in_sel;
  logic [7:0] in_data;
  logic       in_fire;

  logic                           busy, busy_next;
  logic [1:0]                     active_test, active_test_next;
  logic [2:0]                     phase, phase_next;
  logic [sst_seq_pkg::SIZE_W-1:0] offset_counter, offset_counter_next;
  logic [2:0]                     pattern_index, pattern_index_next;
  logic [7:0]                     expected_byte, expected_byte_next;
  logic                           last_was_read, last_was_read_next;

  logic                           res_valid;
  logic [1:0]                     res_kind;
  logic [sst_seq_pkg::SIZE_W-1:0] res_off;
  logic [7:0]                     res_wdata;
  logic                           res_pass;
  logic                           do_enter;
  logic [2:0]                     enter_ph;
  logic                           small_region;
  logic [sst_seq_pkg::SIZE_W-1:0] off_inc;
  logic [sst_seq_pkg::SIZE_W-1:0] off_shift;
  logic [sst_seq_pkg::ADDR_W-1:0] res_sum;
  sst_seq_pkg::result_t           res;

  logic                 out_valid;
  logic                 skid_valid;
  sst_seq_pkg::result_t out_res;
  sst_seq_pkg::result_t skid_res;
  logic                 push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      region_size  <= sst_seq_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sst_seq_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
        sst_seq_pkg::CFG_REGION_SIZE:  region_size  <= cfg_data[sst_seq_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_size = (region_size > sst_seq_pkg::SIZE_LIMIT) ? sst_seq_pkg::SIZE_LIMIT
                                                            : region_size;
  assign small_region = !(eff_size > sst_seq_pkg::SIZE_W'(1));
  assign off_inc      = offset_counter + sst_seq_pkg::SIZE_W'(1);
  assign off_shift    = {offset_counter[sst_seq_pkg::SIZE_W-2:0], 1'b0};

  assign in_fire  = in_valid && !skid_valid;
  assign s_tready = !in_valid || in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (in_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser[0];
      in_sel  <= s_tdata[1:0];
      in_data <= s_tdata[9:2];
    end
  end

  always_comb begin
    busy_next           = busy;
    active_test_next    = active_test;
    phase_next          = phase;
    offset_counter_next = offset_counter;
    pattern_index_next  = pattern_index;
    expected_byte_next  = expected_byte;
    last_was_read_next  = last_was_read;
    res_valid           = 1'b0;
    res_kind            = sst_seq_pkg::KIND_WRITE;
    res_off             = '0;
    res_wdata           = '0;
    res_pass            = 1'b0;
    do_enter            = 1'b0;
    enter_ph            = sst_seq_pkg::ADDR_LOW_FILL;

    if (in_fire) begin
      if (in_mode == sst_seq_pkg::MODE_START) begin
        busy_next           = 1'b1;
        active_test_next    = in_sel;
        phase_next          = '0;
        offset_counter_next = '0;
        pattern_index_next  = '0;
        expected_byte_next  = '0;
        last_was_read_next  = 1'b0;
        if (eff_size == '0) begin
          busy_next = 1'b0;
          res_valid = 1'b1;
          res_kind  = sst_seq_pkg::KIND_DONE;
          res_pass  = 1'b1;
        end else if (in_sel == sst_seq_pkg::TEST_ADDR_BUS) begin
          do_enter = 1'b1;
          enter_ph = sst_seq_pkg::ADDR_LOW_FILL;
        end else begin
          res_valid = 1'b1;
          res_kind  = sst_seq_pkg::KIND_WRITE;
          res_wdata = (in_sel == sst_seq_pkg::TEST_FILL) ? sst_seq_pkg::FILL_SEED
                                                         : sst_seq_pkg::walk_pattern(in_sel, 3'd0);
        end
      end else if (busy) begin
        res_valid = 1'b1;
        if (last_was_read && in_data != expected_byte) begin
          busy_next = 1'b0;
          res_kind  = sst_seq_pkg::KIND_DONE;
          res_pass  = 1'b0;
          res_off   = offset_counter;
        end else if (active_test == sst_seq_pkg::TEST_ADDR_BUS) begin
          unique case (phase) inside
            sst_seq_pkg::ADDR_LOW_FILL, sst_seq_pkg::ADDR_HIGH_FILL: begin
              offset_counter_next = off_shift;
              if (off_shift != '0 && off_shift < eff_size) begin
                last_was_read_next = 1'b0;
                res_kind           = sst_seq_pkg::KIND_WRITE;
                res_off            = off_shift;
                res_wdata          = sst_seq_pkg::PATTERN_AA;
              end else begin
                do_enter = 1'b1;
                enter_ph = phase + 3'd1;
              end
            end
            sst_seq_pkg::ADDR_BASE_AA, sst_seq_pkg::ADDR_BASE_55: begin
              do_enter = 1'b1;
              enter_ph = phase + 3'd1;
            end
            sst_seq_pkg::ADDR_LOW_CHECK: begin
              if (!last_was_read) begin
                last_was_read_next = 1'b1;
                expected_byte_next = sst_seq_pkg::PATTERN_AA;
                res_kind           = sst_seq_pkg::KIND_READ;
                res_off            = '0;
              end else begin
                offset_counter_next = off_shift;
                if (off_shift != '0 && off_shift < eff_size) begin
                  last_was_read_next = 1'b0;
                  res_kind           = sst_seq_pkg::KIND_WRITE;
                  res_off            = off_shift;
                  res_wdata          = sst_seq_pkg::PATTERN_55;
                end else begin
                  do_enter = 1'b1;
                  enter_ph = sst_seq_pkg::ADDR_HIGH_FILL;
                end
              end
            end
            sst_seq_pkg::ADDR_HIGH_CHECK: begin
              offset_counter_next = off_shift;
              if (off_shift != '0 && off_shift < eff_size) begin
                last_was_read_next = 1'b1;
                expected_byte_next = sst_seq_pkg::PATTERN_AA;
                res_kind           = sst_seq_pkg::KIND_READ;
                res_off            = off_shift;
              end else begin
                do_enter = 1'b1;
                enter_ph = sst_seq_pkg::ADDR_END;
              end
            end
            default: begin
              busy_next = 1'b0;
              res_kind  = sst_seq_pkg::KIND_DONE;
              res_pass  = 1'b1;
            end
          endcase
        end else if (active_test == sst_seq_pkg::TEST_FILL) begin
          offset_counter_next = off_inc;
          if (phase == sst_seq_pkg::FILL_WRITE) begin
            if (off_inc < eff_size) begin
              last_was_read_next = 1'b0;
              res_kind           = sst_seq_pkg::KIND_WRITE;
              res_off            = off_inc;
              res_wdata          = sst_seq_pkg::FILL_SEED + off_inc[7:0];
            end else begin
              phase_next          = phase + 3'd1;
              offset_counter_next = '0;
              if (eff_size == '0) begin
                busy_next = 1'b0;
                res_kind  = sst_seq_pkg::KIND_DONE;
                res_pass  = 1'b1;
              end else begin
                last_was_read_next = 1'b1;
                expected_byte_next = sst_seq_pkg::FILL_SEED;
                res_kind           = sst_seq_pkg::KIND_READ;
                res_off            = '0;
              end
            end
          end else if (off_inc < eff_size) begin
            last_was_read_next = 1'b1;
            expected_byte_next = sst_seq_pkg::FILL_SEED + off_inc[7:0];
            res_kind           = sst_seq_pkg::KIND_READ;
            res_off            = off_inc;
          end else begin
            busy_next = 1'b0;
            res_kind  = sst_seq_pkg::KIND_DONE;
            res_pass  = 1'b1;
          end
        end else begin
          if (!last_was_read) begin
            last_was_read_next = 1'b1;
            expected_byte_next = sst_seq_pkg::walk_pattern(active_test, pattern_index);
            res_kind           = sst_seq_pkg::KIND_READ;
            res_off            = offset_counter;
          end else if (pattern_index != 3'd7) begin
            pattern_index_next = pattern_index + 3'd1;
            last_was_read_next = 1'b0;
            res_kind           = sst_seq_pkg::KIND_WRITE;
            res_off            = offset_counter;
            res_wdata          = sst_seq_pkg::walk_pattern(active_test, pattern_index + 3'd1);
          end else begin
            pattern_index_next  = '0;
            offset_counter_next = off_inc;
            if (off_inc < eff_size) begin
              last_was_read_next = 1'b0;
              res_kind           = sst_seq_pkg::KIND_WRITE;
              res_off            = off_inc;
              res_wdata          = sst_seq_pkg::walk_pattern(active_test, 3'd0);
            end else begin
              busy_next = 1'b0;
              res_kind  = sst_seq_pkg::KIND_DONE;
              res_pass  = 1'b1;
            end
          end
        end
      end
    end

    if (do_enter) begin
      res_valid  = 1'b1;
      phase_next = enter_ph;
      unique case (enter_ph)
        sst_seq_pkg::ADDR_LOW_FILL, sst_seq_pkg::ADDR_LOW_CHECK,
        sst_seq_pkg::ADDR_HIGH_FILL: begin
          offset_counter_next = sst_seq_pkg::SIZE_W'(1);
          last_was_read_next  = 1'b0;
          res_kind            = sst_seq_pkg::KIND_WRITE;
          if (small_region) begin
            res_off = '0;
            if (enter_ph == sst_seq_pkg::ADDR_LOW_FILL) begin
              phase_next = sst_seq_pkg::ADDR_BASE_AA;
              res_wdata  = sst_seq_pkg::PATTERN_AA;
            end else begin
              phase_next = sst_seq_pkg::ADDR_BASE_55;
              res_wdata  = sst_seq_pkg::PATTERN_55;
            end
          end else begin
            res_off   = sst_seq_pkg::SIZE_W'(1);
            res_wdata = (enter_ph == sst_seq_pkg::ADDR_LOW_CHECK) ? sst_seq_pkg::PATTERN_55
                                                                  : sst_seq_pkg::PATTERN_AA;
          end
        end
        sst_seq_pkg::ADDR_BASE_AA: begin
          last_was_read_next = 1'b0;
          res_kind           = sst_seq_pkg::KIND_WRITE;
          res_off            = '0;
          res_wdata          = sst_seq_pkg::PATTERN_AA;
        end
        sst_seq_pkg::ADDR_BASE_55: begin
          last_was_read_next = 1'b0;
          res_kind           = sst_seq_pkg::KIND_WRITE;
          res_off            = '0;
          res_wdata          = sst_seq_pkg::PATTERN_55;
        end
        sst_seq_pkg::ADDR_HIGH_CHECK: begin
          offset_counter_next = sst_seq_pkg::SIZE_W'(1);
          if (small_region) begin
            phase_next = sst_seq_pkg::ADDR_END;
            busy_next  = 1'b0;
            res_kind   = sst_seq_pkg::KIND_DONE;
            res_pass   = 1'b1;
          end else begin
            last_was_read_next = 1'b1;
            expected_byte_next = sst_seq_pkg::PATTERN_AA;
            res_kind           = sst_seq_pkg::KIND_READ;
            res_off            = sst_seq_pkg::SIZE_W'(1);
          end
        end
        default: begin
          phase_next = sst_seq_pkg::ADDR_END;
          busy_next  = 1'b0;
          res_kind   = sst_seq_pkg::KIND_DONE;
          res_pass   = 1'b1;
        end
      endcase
    end
  end

  assign res_sum = base_address + sst_seq_pkg::ADDR_W'(res_off);

  always_comb begin
    res.access_kind    = res_kind;
    res.access_address = (res_kind == sst_seq_pkg::KIND_DONE) ? '0 : res_sum;
    res.write_data     = (res_kind == sst_seq_pkg::KIND_WRITE) ? res_wdata : '0;
    res.test_passed    = (res_kind == sst_seq_pkg::KIND_DONE) && res_pass;
    res.fail_address   = (res_kind == sst_seq_pkg::KIND_DONE && !res_pass) ? res_sum : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      active_test    <= '0;
      phase          <= '0;
      offset_counter <= '0;
      pattern_index  <= '0;
      expected_byte  <= '0;
      last_was_read  <= 1'b0;
    end else begin
      busy           <= busy_next;
      active_test    <= active_test_next;
      phase          <= phase_next;
      offset_counter <= offset_counter_next;
      pattern_index  <= pattern_index_next;
      expected_byte  <= expected_byte_next;
      last_was_read  <= last_was_read_next;
    end
  end

  assign push = in_fire && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_tready) begin
      if (push) begin
        skid_res <= res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (push) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.access_kind;
  assign m_tdata  = {7'b0, out_res.fail_address, out_res.test_passed,
                     out_res.write_data, out_res.access_address};

endmodule

`default_nettype wire

@@ rtl/sst_seq_checker.sv @@
// ---------------------------------------------------------------------------
// sst_seq_checker
// Port-level checks on the result channel of the self-test sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sst_seq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  `SST_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `SST_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !m_tvalid)
  `SST_ASSERT_NOW(a_request_no_verdict, clk, rst, m_tvalid && m_tuser != sst_seq_pkg::KIND_DONE, m_tdata[72:40] == 33'd0)
  `SST_ASSERT_NOW(a_read_no_data, clk, rst, m_tvalid && m_tuser == sst_seq_pkg::KIND_READ, m_tdata[39:32] == 8'd0)

endmodule

bind sram_self_test_sequencer_top sst_seq_checker u_sst_seq_checker (.*);

`default_nettype wire

@@ tb/sst_access_check.sv @@
// ---------------------------------------------------------------------------
// Access sequence checker
// Watches the configuration, start/completion and request channels of the
// memory self-test sequencer. It keeps its own copy of the test state, works
// out the next request or done report for each start beat and each completion
// in a test, and checks each accepted output beat against the oldest waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module sst_access_check
  import sst_seq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [15:0]       s_tdata,
  input  logic [0:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [79:0]       m_tdata,
  input  logic [1:0]        m_tuser,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  output int unsigned       fail_count,
  output int unsigned       outstanding
);

  localparam logic [2:0] FILL_VERIFY = 3'd1;

  logic [31:0]       base_q;
  logic [SIZE_W-1:0] size_q;
  logic              run_busy;
  logic [1:0]        run_test;
  logic [2:0]        run_phase;
  logic [SIZE_W-1:0] offset;
  logic [2:0]        bit_idx;
  logic [7:0]        want_byte;
  logic              pending_read;

  result_t     expected_accesses[$];
  int unsigned mismatches;

  function automatic logic [SIZE_W-1:0] span();
    return (size_q > SIZE_LIMIT) ? SIZE_LIMIT : size_q;
  endfunction

  function automatic logic [31:0] addr_at(input logic [SIZE_W-1:0] off);
    return base_q + 32'(off);
  endfunction

  function automatic result_t issue_write(input logic [31:0] addr, input logic [7:0] data);
    result_t r;
    r = '0;
    pending_read = 1'b0;
    r.access_kind = KIND_WRITE;
    r.access_address = addr;
    r.write_data = data;
    return r;
  endfunction

  function automatic result_t issue_read(input logic [31:0] addr, input logic [7:0] want);
    result_t r;
    r = '0;
    pending_read = 1'b1;
    want_byte = want;
    r.access_kind = KIND_READ;
    r.access_address = addr;
    return r;
  endfunction

  function automatic result_t report_done(input logic passed, input logic [31:0] where);
    result_t r;
    r = '0;
    run_busy = 1'b0;
    r.access_kind = KIND_DONE;
    r.test_passed = passed;
    r.fail_address = passed ? 32'd0 : where;
    return r;
  endfunction

  function automatic logic [7:0] walk_byte();
    logic [7:0] one_hot;
    one_hot = 8'h01 << bit_idx;
    return (run_test == TEST_WALK_ONES) ? one_hot : ~one_hot;
  endfunction

  // Phases that probe offsets are skipped when offset 1 does not lie below
  // the region size, that is when the region holds at most one byte.
  function automatic result_t addr_enter(input logic [2:0] first);
    logic [2:0] ph;
    logic       found;
    result_t    r;
    ph = first;
    found = 1'b0;
    r = '0;
    while (!found) begin
      run_phase = ph;
      if (ph == ADDR_BASE_AA) begin
        r = issue_write(addr_at('0), PATTERN_AA);
        found = 1'b1;
      end else if (ph == ADDR_BASE_55) begin
        r = issue_write(addr_at('0), PATTERN_55);
        found = 1'b1;
      end else if (ph >= ADDR_END) begin
        r = report_done(1'b1, 32'd0);
        found = 1'b1;
      end else begin
        offset = SIZE_W'(1);
        if (span() > SIZE_W'(1)) begin
          case (ph)
            ADDR_LOW_FILL, ADDR_HIGH_FILL: r = issue_write(addr_at(offset), PATTERN_AA);
            ADDR_LOW_CHECK:                r = issue_write(addr_at(offset), PATTERN_55);
            default:                       r = issue_read(addr_at(offset), PATTERN_AA);
          endcase
          found = 1'b1;
        end else begin
          ph = ph + 3'd1;
        end
      end
    end
    return r;
  endfunction

  function automatic result_t addr_advance();
    logic [SIZE_W-1:0] nxt;
    logic              fits;
    result_t           r;
    nxt = offset << 1;
    fits = (nxt != '0) && (nxt < span());
    case (run_phase)
      ADDR_LOW_FILL, ADDR_HIGH_FILL: begin
        offset = nxt;
        if (fits) r = issue_write(addr_at(nxt), PATTERN_AA);
        else r = addr_enter(run_phase + 3'd1);
      end
      ADDR_BASE_AA, ADDR_BASE_55: begin
        r = addr_enter(run_phase + 3'd1);
      end
      ADDR_LOW_CHECK: begin
        if (!pending_read) begin
          r = issue_read(addr_at('0), PATTERN_AA);
        end else begin
          offset = nxt;
          if (fits) r = issue_write(addr_at(nxt), PATTERN_55);
          else r = addr_enter(ADDR_HIGH_FILL);
        end
      end
      ADDR_HIGH_CHECK: begin
        offset = nxt;
        if (fits) r = issue_read(addr_at(nxt), PATTERN_AA);
        else r = addr_enter(ADDR_END);
      end
      default: begin
        r = report_done(1'b1, 32'd0);
      end
    endcase
    return r;
  endfunction

  function automatic result_t walk_advance();
    result_t r;
    if (!pending_read) begin
      r = issue_read(addr_at(offset), walk_byte());
    end else if (bit_idx < 3'd7) begin
      bit_idx = bit_idx + 3'd1;
      r = issue_write(addr_at(offset), walk_byte());
    end else begin
      bit_idx = '0;
      offset = offset + SIZE_W'(1);
      if (offset < span()) r = issue_write(addr_at(offset), walk_byte());
      else r = report_done(1'b1, 32'd0);
    end
    return r;
  endfunction

  function automatic result_t fill_advance();
    result_t r;
    offset = offset + SIZE_W'(1);
    if (run_phase == FILL_WRITE) begin
      if (offset < span()) begin
        r = issue_write(addr_at(offset), FILL_SEED + offset[7:0]);
      end else begin
        run_phase = FILL_VERIFY;
        offset = '0;
        if (span() == '0) r = report_done(1'b1, 32'd0);
        else r = issue_read(addr_at('0), FILL_SEED);
      end
    end else if (offset < span()) begin
      r = issue_read(addr_at(offset), FILL_SEED + offset[7:0]);
    end else begin
      r = report_done(1'b1, 32'd0);
    end
    return r;
  endfunction

  function automatic bit sequence_step(input logic mode, input logic [1:0] sel,
                                       input logic [7:0] rd, output result_t r);
    r = '0;
    if (mode == MODE_START) begin
      run_busy = 1'b1;
      run_test = sel;
      run_phase = '0;
      offset = '0;
      bit_idx = '0;
      want_byte = '0;
      pending_read = 1'b0;
      if (span() == '0) r = report_done(1'b1, 32'd0);
      else if (sel == TEST_ADDR_BUS) r = addr_enter(ADDR_LOW_FILL);
      else if (sel == TEST_FILL) r = issue_write(addr_at('0), FILL_SEED);
      else r = issue_write(addr_at('0), walk_byte());
      return 1'b1;
    end
    if (!run_busy) return 1'b0;
    if (pending_read && rd != want_byte) r = report_done(1'b0, addr_at(offset));
    else if (run_test == TEST_ADDR_BUS) r = addr_advance();
    else if (run_test == TEST_FILL) r = fill_advance();
    else r = walk_advance();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t fresh;
    if (rst) begin
      base_q = '0;
      size_q = SIZE_RESET;
      run_busy = 1'b0;
      run_test = '0;
      run_phase = '0;
      offset = '0;
      bit_idx = '0;
      want_byte = '0;
      pending_read = 1'b0;
      expected_accesses.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.access_kind = m_tuser;
        got.access_address = m_tdata[31:0];
        got.write_data = m_tdata[39:32];
        got.test_passed = m_tdata[40];
        got.fail_address = m_tdata[72:41];
        if (expected_accesses.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected beat kind %0d addr %h data %h pass %0d fail %h",
                     $time, got.access_kind, got.access_address, got.write_data,
                     got.test_passed, got.fail_address);
          mismatches++;
        end else begin
          want = expected_accesses.pop_front();
          if (got.access_kind !== want.access_kind ||
              got.access_address !== want.access_address ||
              got.write_data !== want.write_data ||
              got.test_passed !== want.test_passed ||
              got.fail_address !== want.fail_address) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch, expected kind %0d addr %h data %h pass %0d fail %h",
                       $time, want.access_kind, want.access_address, want.write_data,
                       want.test_passed, want.fail_address);
              $display("%0t: mismatch, got kind %0d addr %h data %h pass %0d fail %h",
                       $time, got.access_kind, got.access_address, got.write_data,
                       got.test_passed, got.fail_address);
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE_ADDRESS) base_q = cfg_data;
        else size_q = cfg_data[SIZE_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        if (sequence_step(s_tuser[0], s_tdata[1:0], s_tdata[9:2], fresh))
          expected_accesses.push_back(fresh);
      end
    end
    outstanding <= expected_accesses.size();
    fail_count <= mismatches;
  end

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// Memory self-test sequencer testbench
// Plays the memory side of the sequencer: it starts tests, answers each
// write and read request with a completion beat, returns stored bytes on
// reads and now and then a corrupted one. Directed runs cover empty and
// tiny regions and wrapping addresses; random runs mix full and abandoned
// tests, register changes, stray beats and a long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import sst_seq_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT   = 8000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycles;
  int unsigned beats_sent;
  int unsigned send_quiet;
  int unsigned take_quiet;
  bit          hold_req;
  logic [7:0]  mem_img[bit [31:0]];

  sram_self_test_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sst_access_check u_access_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(inout int unsigned quiet);
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd2;
      3:       return $urandom_range(25, 300);
      4:       return 32'(SIZE_LIMIT);
      5: begin
        case ($urandom_range(0, 2))
          0:       return 32'h01FF_FFFF;
          1:       return 32'h0100_0001;
          default: return $urandom;
        endcase
      end
      default: return $urandom_range(3, 24);
    endcase
  endfunction

  task automatic send_beat(input logic mode, input logic [1:0] sel, input logic [7:0] data);
    int unsigned gap;
    gap = draw_wait(send_quiet);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {6'b0, data, sel};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_reply(output logic [1:0] kind, output logic [31:0] addr,
                            output logic [7:0] wdata);
    do @(posedge clk); while (!(m_tvalid && m_tready));
    kind = m_tuser;
    addr = m_tdata[31:0];
    wdata = m_tdata[39:32];
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input bit set_base, input logic [31:0] base,
                           input bit set_size, input logic [31:0] size);
    drain();
    if (set_base) write_reg(CFG_BASE_ADDRESS, base);
    if (set_size) write_reg(CFG_REGION_SIZE, size);
    cfg_valid <= 1'b0;
  endtask

  // Acts as the memory: each request is answered by one completion beat.
  // Runs stop at a done report or after max_steps completions, leaving
  // the test running and its last request unanswered.
  task automatic run_test(input logic [1:0] sel, input int unsigned max_steps,
                          input int unsigned spoil_odds, input bit reshape);
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  rd;
    int unsigned steps;
    bit          finished;
    steps = 0;
    finished = 1'b0;
    drain();
    send_beat(MODE_START, sel, 8'($urandom));
    s_tvalid <= 1'b0;
    while (!finished) begin
      wait_reply(kind, addr, wdata);
      if (kind == KIND_DONE || steps >= max_steps) begin
        finished = 1'b1;
      end else begin
        rd = 8'($urandom);
        if (kind == KIND_WRITE) begin
          mem_img[addr] = wdata;
        end else begin
          if (mem_img.exists(addr)) rd = mem_img[addr];
          if (spoil_odds != 0 && $urandom_range(1, spoil_odds) == 1)
            rd = rd ^ (8'h01 << $urandom_range(0, 7));
        end
        if (reshape && $urandom_range(0, 59) == 0) begin
          write_reg(CFG_REGION_SIZE, $urandom_range(0, 24));
          cfg_valid <= 1'b0;
        end
        send_beat(MODE_COMPLETE, 2'($urandom), rd);
        s_tvalid <= 1'b0;
        steps++;
      end
    end
  endtask

  task automatic stray_beats(input int unsigned count);
    repeat (count) send_beat(1'($urandom), 2'($urandom), 8'($urandom));
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // The output side stops for a long stretch while completion beats of a fill
  // test keep arriving, so the block backs up and stalls its input.
  task automatic pressure_burst();
    configure(1'b1, $urandom, 1'b1, 32'd4096);
    hold_req = 1'b1;
    send_beat(MODE_START, TEST_FILL, 8'($urandom));
    repeat (40) send_beat(MODE_COMPLETE, 2'($urandom), 8'($urandom));
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int unsigned gap;
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = draw_wait(take_quiet);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int unsigned mark;
    bit          pressed;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    cycles = 0;
    beats_sent = 0;
    send_quiet = 0;
    take_quiet = 0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    configure(1'b0, 32'd0, 1'b1, 32'd0);
    run_test(TEST_WALK_ONES, 4, 0, 1'b0);
    stray_beats(0);
    send_beat(MODE_COMPLETE, TEST_FILL, 8'hFF);
    s_tvalid <= 1'b0;
    configure(1'b1, 32'hFFFF_FFFE, 1'b1, 32'd3);
    run_test(TEST_ADDR_BUS, 100, 0, 1'b0);
    configure(1'b0, 32'd0, 1'b1, 32'd2);
    run_test(TEST_FILL, 100, 1, 1'b0);
    configure(1'b1, 32'hFFFF_FFFF, 1'b1, 32'd1);
    run_test(TEST_WALK_ONES, 3, 0, 1'b0);
    run_test(TEST_WALK_ZEROS, 5, 1, 1'b0);

    pressed = 1'b0;
    mark = beats_sent;
    while (beats_sent - mark < RANDOM_ITEMS) begin
      if (!pressed && beats_sent - mark >= RANDOM_ITEMS / 3) begin
        pressure_burst();
        pressed = 1'b1;
      end else if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0: configure(1'b1, pick_base(), 1'b0, 32'd0);
          1: configure(1'b0, 32'd0, 1'b1, pick_size());
          2: configure(1'b1, pick_base(), 1'b1, pick_size());
          default: ;
        endcase
        run_test(2'($urandom), $urandom_range(10, 200),
                 ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 150), 1'b1);
      end else begin
        stray_beats($urandom_range(1, 8));
      end
    end

    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
